// File: rtl/assert_macros.svh
// Assertion macros shared by the route length block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/rldc_pkg.sv
// Package for the route length block: sizes and shared types.
// No dependencies.
package rldc_pkg;
    localparam int ORDER_DEPTH_DEF   = 1024;
    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 4;
    localparam int IDX_BITS          = 10;
    localparam int DEM_BITS          = 16;
    localparam int DSUM_BITS         = 26;
    localparam int COST_BITS         = 32;
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_VISIT = 1'b1;
endpackage

// File: rtl/rldc_sqrt.sv
// Iterative unsigned square root, two result bits per cycle.
// Depends on rldc_pkg.
module rldc_sqrt import rldc_pkg::*; #(
    parameter int IN_BITS = 80
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [IN_BITS-1:0]   i_value,
    output logic                 o_done,
    output logic [IN_BITS/2-1:0] o_root
);
    localparam int HB = IN_BITS / 2;
    localparam int STEPS = (HB + 1) / 2;
    localparam int CW = $clog2(STEPS + 1);
    logic [IN_BITS-1:0] r_rem, n_rem, r_val, n_val;
    logic [HB-1:0] r_root, n_root;
    logic [CW-1:0] r_cnt;
    logic r_busy;
    always_comb begin
        logic [IN_BITS+1:0] rem, trial;
        logic [HB-1:0] rt;
        logic [IN_BITS-1:0] v;
        rem = {2'b00, r_rem};
        rt = r_root;
        v = r_val;
        for (int k = 0; k < 2; k++) begin
            rem = {rem[IN_BITS-1:0], v[IN_BITS-1 -: 2]};
            v = {v[IN_BITS-3:0], 2'b00};
            trial = {rt, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                rt = {rt[HB-2:0], 1'b1};
            end else begin
                rt = {rt[HB-2:0], 1'b0};
            end
        end
        n_rem = rem[IN_BITS-1:0];
        n_root = rt;
        n_val = v;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CW'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
        if (i_start) begin
            r_rem <= '0;
            r_root <= '0;
            r_val <= (HB % 2 == 1) ? {2'b00, i_value[IN_BITS-1:2]} : i_value;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_root <= n_root;
            r_val <= n_val;
        end
    end
    assign o_done = r_busy && (r_cnt == CW'(1));
    assign o_root = n_root;
endmodule

// File: rtl/rldc_div.sv
// Iterative signed divide with truncation toward zero and clamping.
// Depends on rldc_pkg.
module rldc_div import rldc_pkg::*; #(
    parameter int NUM_BITS = 43,
    parameter int OUT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic [DSUM_BITS-1:0]       i_den,
    output logic                       o_done,
    output logic [OUT_BITS-1:0]        o_quot
);
    localparam int CW = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_q, r_mag;
    logic [DSUM_BITS:0] r_rem;
    logic [DSUM_BITS-1:0] r_den;
    logic r_neg, r_busy;
    logic [CW-1:0] r_cnt;
    logic [DSUM_BITS:0] w_sh;
    logic r_fin;
    logic [NUM_BITS:0] w_lim;
    assign w_sh = {r_rem[DSUM_BITS-1:0], r_mag[NUM_BITS-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CW'(NUM_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
        if (i_start) begin
            r_neg <= i_num[NUM_BITS-1];
            r_mag <= i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : NUM_BITS'(i_num);
            r_rem <= '0;
            r_q <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_mag <= {r_mag[NUM_BITS-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q <= {r_q[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q <= {r_q[NUM_BITS-2:0], 1'b0};
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fin <= 1'b0;
        else r_fin <= r_busy && (r_cnt == CW'(1));
    end
    always_comb begin
        w_lim = r_neg ? (NUM_BITS+1)'(1) << (OUT_BITS-1)
                      : ((NUM_BITS+1)'(1) << (OUT_BITS-1)) - 1'b1;
        if ({1'b0, r_q} > w_lim) o_quot = r_neg ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                              : {1'b0, {(OUT_BITS-1){1'b1}}};
        else o_quot = r_neg ? OUT_BITS'(-r_q) : OUT_BITS'(r_q);
    end
    assign o_done = r_fin;
endmodule

// File: rtl/route_length_demand_centroid.sv
// Route length, demand and centroid over a stored order table.
// Table writes do not hold off the input. A visit holds the input until its leg's square
// root is done. A final visit also holds it for the closing leg back to the depot and,
// with nonzero demand, the centroid divide before it raises the result, and waits
// longer while an earlier result waits.
// Reset clears the route sums and depot register; the table is not cleared.
module route_length_demand_centroid import rldc_pkg::*; #(
    parameter int ORDER_DEPTH   = ORDER_DEPTH_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: order_index, coord_x, coord_y, demand (COORD_BITS each coord), zero fill
    input  logic [((IDX_BITS+2*COORD_BITS+DEM_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // action
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: route_cost, route_demand, center_x, center_y, zero fill
    output logic [((COST_BITS+DSUM_BITS+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tuser,   // no_demand
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [IDX_BITS-1:0] i_cfg_data
);
    localparam int AW = $clog2(ORDER_DEPTH);
    localparam int WB = COORD_BITS + 27;
    localparam int DB = COORD_BITS + 1;
    localparam int SQB = 2 * (DB + FRACTION_BITS + 1);
    localparam int OW = ((COST_BITS+DSUM_BITS+2*COORD_BITS+7)/8)*8;
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_DEP = 4'd2, S_ORD = 4'd3,
        S_SQ = 4'd4, S_SQW = 4'd5, S_CRD = 4'd6, S_CDEP = 4'd7, S_CSQW = 4'd8,
        S_DIV = 4'd9, S_OUT = 4'd10, S_MUL = 4'd11;

    logic [COORD_BITS-1:0] mem_x [ORDER_DEPTH];
    logic [COORD_BITS-1:0] mem_y [ORDER_DEPTH];
    logic [DEM_BITS-1:0]   mem_d [ORDER_DEPTH];
    logic [COORD_BITS-1:0] r_rx, r_ry;
    logic [DEM_BITS-1:0]   r_rd;
    logic r_rok;

    logic [3:0] r_st;
    logic [IDX_BITS-1:0] r_depot, r_idx, w_ridx;
    logic r_last, r_inr, w_rd_en;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_cx, r_cy;
    logic [COST_BITS-1:0] r_cost;
    logic [DSUM_BITS-1:0] r_dsum;
    logic [WB-1:0] r_wx, r_wy;
    logic signed [COORD_BITS-1:0] w_ex, w_ey;
    logic [DEM_BITS-1:0] w_ed;

    logic [IDX_BITS-1:0] w_in_idx;
    logic signed [COORD_BITS-1:0] w_in_x, w_in_y;
    logic [DEM_BITS-1:0] w_in_d;
    assign w_in_idx = s_axis_tdata[IDX_BITS-1:0];
    assign w_in_x = s_axis_tdata[IDX_BITS +: COORD_BITS];
    assign w_in_y = s_axis_tdata[IDX_BITS+COORD_BITS +: COORD_BITS];
    assign w_in_d = s_axis_tdata[IDX_BITS+2*COORD_BITS +: DEM_BITS];

    logic w_acc;
    assign s_axis_tready = (r_st == S_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_rd_en = 1'b0;
        w_ridx = r_depot;
        unique case (r_st)
            S_RD:  begin w_rd_en = 1'b1; w_ridx = r_depot; end
            S_DEP: begin w_rd_en = 1'b1; w_ridx = r_idx; end
            S_CRD: begin w_rd_en = 1'b1; w_ridx = r_depot; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && s_axis_tuser == ACT_WRITE && 32'(w_in_idx) < ORDER_DEPTH) begin
            mem_x[AW'(w_in_idx)] <= w_in_x;
            mem_y[AW'(w_in_idx)] <= w_in_y;
            mem_d[AW'(w_in_idx)] <= w_in_d;
        end
        if (w_rd_en) begin
            r_rx <= mem_x[AW'(w_ridx)];
            r_ry <= mem_y[AW'(w_ridx)];
            r_rd <= mem_d[AW'(w_ridx)];
            r_rok <= 32'(w_ridx) < ORDER_DEPTH;
        end
    end
    assign w_ex = r_rok ? r_rx : '0;
    assign w_ey = r_rok ? r_ry : '0;
    assign w_ed = r_rok ? r_rd : '0;

    // leg: from r_px/r_py to a target coordinate
    logic signed [COORD_BITS-1:0] r_tx, r_ty;
    logic [DB-1:0] r_dx, r_dy;
    logic [2*DB:0] r_d2;
    logic w_sq_start, w_sq_done;
    logic [SQB/2-1:0] w_root;
    logic [SQB-1:0] w_sq_in;
    assign w_sq_in = SQB'(r_d2) << (2 * FRACTION_BITS);
    rldc_sqrt #(.IN_BITS(SQB)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_value(w_sq_in), .o_done(w_sq_done), .o_root(w_root));
    assign w_sq_start = (r_st == S_SQ);

    logic [COST_BITS:0] w_csum;
    assign w_csum = {1'b0, r_cost} + (COST_BITS+1)'(w_root);

    logic w_dv_start, w_dvx_done, w_dvy_done;
    logic [COORD_BITS-1:0] w_qx, w_qy;
    rldc_div #(.NUM_BITS(WB), .OUT_BITS(COORD_BITS)) u_divx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dv_start), .i_num(r_wx),
        .i_den(r_dsum), .o_done(w_dvx_done), .o_quot(w_qx));
    rldc_div #(.NUM_BITS(WB), .OUT_BITS(COORD_BITS)) u_divy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dv_start), .i_num(r_wy),
        .i_den(r_dsum), .o_done(w_dvy_done), .o_quot(w_qy));
    logic r_closing;
    assign w_dv_start = (r_st == S_CSQW) && w_sq_done && (r_dsum != '0);

    function automatic logic [DB-1:0] absdiff(input logic signed [COORD_BITS-1:0] a,
                                              input logic signed [COORD_BITS-1:0] b);
        logic signed [DB-1:0] d;
        d = DB'(a) - DB'(b);
        return d[DB-1] ? DB'(-d) : DB'(d);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_depot <= '0;
            r_inr <= 1'b0;
            m_axis_tvalid <= 1'b0;
            r_cost <= '0;
            r_dsum <= '0;
            r_wx <= '0;
            r_wy <= '0;
            r_px <= '0;
            r_py <= '0;
        end else begin
            if (i_cfg_valid) r_depot <= i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (w_acc && s_axis_tuser == ACT_VISIT) begin
                    r_idx <= w_in_idx;
                    r_last <= s_axis_tlast;
                    r_st <= r_inr ? S_DEP : S_RD;
                end
                S_RD: r_st <= S_DEP;
                S_DEP: begin
                    if (!r_inr) begin
                        r_px <= w_ex;
                        r_py <= w_ey;
                        r_cost <= '0;
                        r_dsum <= '0;
                        r_wx <= '0;
                        r_wy <= '0;
                        r_inr <= 1'b1;
                    end
                    r_st <= S_ORD;
                end
                S_ORD: begin
                    r_dx <= absdiff(r_px, w_ex);
                    r_dy <= absdiff(r_py, w_ey);
                    r_tx <= w_ex;
                    r_ty <= w_ey;
                    r_dsum <= r_dsum + DSUM_BITS'(w_ed);
                    r_wx <= r_wx + WB'($signed(w_ex) * $signed({1'b0, w_ed}));
                    r_wy <= r_wy + WB'($signed(w_ey) * $signed({1'b0, w_ed}));
                    r_closing <= 1'b0;
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_d2 <= (2*DB+1)'(r_dx * r_dx) + (2*DB+1)'(r_dy * r_dy);
                    r_st <= S_SQ;
                end
                S_SQ: r_st <= r_closing ? S_CSQW : S_SQW;
                S_SQW: if (w_sq_done) begin
                    r_cost <= w_csum[COST_BITS] ? '1 : w_csum[COST_BITS-1:0];
                    r_px <= r_tx;
                    r_py <= r_ty;
                    r_st <= r_last ? S_CRD : S_IDLE;
                end
                S_CRD: r_st <= S_CDEP;
                S_CDEP: begin
                    r_dx <= absdiff(r_px, w_ex);
                    r_dy <= absdiff(r_py, w_ey);
                    r_closing <= 1'b1;
                    r_st <= S_MUL;
                end
                S_CSQW: if (w_sq_done) begin
                    r_cost <= w_csum[COST_BITS] ? '1 : w_csum[COST_BITS-1:0];
                    r_inr <= 1'b0;
                    r_cx <= '0;
                    r_cy <= '0;
                    r_st <= (r_dsum != '0) ? S_DIV : S_OUT;
                end
                S_DIV: if (w_dvx_done) begin
                    r_cx <= w_qx;
                    r_cy <= w_qy;
                    r_st <= S_OUT;
                end
                S_OUT: if (!m_axis_tvalid) begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata <= OW'({r_cy, r_cx, r_dsum, r_cost});
                    m_axis_tuser <= (r_dsum == '0);
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPLY(a_div_pair, i_clk, i_rst_n, w_dvx_done, w_dvy_done)
    `ASSERT_IMPLY(a_no_accept_busy, i_clk, i_rst_n, r_st != S_IDLE, !s_axis_tready)
    `ASSERT_NEXT(a_out_after, i_clk, i_rst_n, r_st == S_OUT && !m_axis_tvalid, m_axis_tvalid)
endmodule
